// ===== rtl/modular_exponentiation_assert.svh =====
// Assertion macros shared by the modular exponentiation RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_HOLDS(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      bit_cnt_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// Computes base to the power exponent modulo modulus, one beat at a time, by
// right-to-left square-and-multiply over a single bit-serial modular
// multiplier that handles one multiplier bit per cycle. The base is first
// reduced in one modular product, then every exponent bit up to the highest
// set one costs a squaring and, where the bit is set, one more product; the
// last squaring is skipped, so short exponents need far fewer products. A
// zero modulus skips the multiplier and goes straight to the done state,
// returning a result of zero with zero_modulus set. Only one item is in work
// at a time; a finished result waits in the output register while the next
// item is taken.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t base,
  input  word_t exponent,
  input  word_t modulus,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t power_result,
  output logic  zero_modulus
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_MULT   = 5'b00100,
    S_SQUARE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  word_t base_r;
  word_t exp_r;
  word_t mod_r;
  word_t acc_r;
  logic  err;

  logic  mul_start;
  word_t mul_a;
  word_t mul_b;
  word_t mul_m;
  logic  mul_busy;
  logic  mul_done;
  word_t mul_result;

  logic  dec;
  word_t dec_exp;
  word_t one_in;
  logic  out_load;

  assign one_in   = word_t'(modulus != word_t'(1));
  assign in_stall = (state != S_IDLE);
  assign mul_m    = (state == S_IDLE) ? modulus : mod_r;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = acc_r;
    mul_b      = base_r;
    dec        = 1'b0;
    dec_exp    = exp_r;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (modulus == '0) begin
            state_next = S_DONE;
          end else begin
            mul_start  = 1'b1;
            mul_a      = one_in;
            mul_b      = base;
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          dec     = 1'b1;
          dec_exp = exp_r;
        end
      end
      S_MULT: begin
        if (mul_done) begin
          if ((exp_r >> 1) == '0) begin
            state_next = S_DONE;
          end else begin
            mul_start  = 1'b1;
            mul_a      = base_r;
            mul_b      = base_r;
            state_next = S_SQUARE;
          end
        end
      end
      S_SQUARE: begin
        if (mul_done) begin
          dec     = 1'b1;
          dec_exp = exp_r >> 1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // The fresh base comes straight from the multiplier in both cases.
    if (dec) begin
      if (dec_exp == '0) begin
        state_next = S_DONE;
      end else if (dec_exp[0]) begin
        mul_start  = 1'b1;
        mul_a      = acc_r;
        mul_b      = mul_result;
        state_next = S_MULT;
      end else begin
        mul_start  = 1'b1;
        mul_a      = mul_result;
        mul_b      = mul_result;
        state_next = S_SQUARE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      exp_r <= exponent;
      mod_r <= modulus;
      acc_r <= one_in;
      err   <= (modulus == '0);
    end
    if (mul_done && (state == S_REDUCE || state == S_SQUARE)) begin
      base_r <= mul_result;
    end
    if (mul_done && state == S_SQUARE) begin
      exp_r <= exp_r >> 1;
    end
    if (mul_done && state == S_MULT) begin
      acc_r <= mul_result;
    end
    if (out_load) begin
      power_result <= err ? '0 : acc_r;
      zero_modulus <= err;
    end
  end

  mexp_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (mul_m),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_result)
  );

`include "modular_exponentiation_assert.svh"

  `MEXP_ASSERT_HOLDS(a_err_zero, out_valid && zero_modulus, power_result == '0)
  `MEXP_ASSERT_HOLDS(a_done_wait, mul_done, state != S_IDLE && state != S_DONE)
  `MEXP_ASSERT_HOLDS(a_mult_bit, state == S_MULT, exp_r[0])
  `MEXP_ASSERT_HOLDS(a_no_overlap, mul_start, !mul_busy)

endmodule

// ===== rtl/mexp_mulmod.sv =====
`timescale 1ns / 1ps

module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  input  word_t m,
  output logic  busy,
  output logic  done,
  output word_t result
);

  bit_cnt_t cnt;
  word_t    acc;
  word_t    acc_next;
  word_t    a_r;
  word_t    b_sh;
  word_t    m_r;

  logic [DATA_WIDTH:0] dbl;
  logic [DATA_WIDTH:0] sum;
  word_t               half;

  // One multiplier bit per cycle: double the partial product, then add a
  // when the current bit of b is set, reducing after each step.
  always_comb begin
    dbl  = {acc, 1'b0};
    half = (dbl >= {1'b0, m_r}) ? word_t'(dbl - {1'b0, m_r}) : dbl[DATA_WIDTH-1:0];
    sum  = {1'b0, half} + {1'b0, a_r};
    if (b_sh[DATA_WIDTH-1]) begin
      acc_next = (sum >= {1'b0, m_r}) ? word_t'(sum - {1'b0, m_r}) : sum[DATA_WIDTH-1:0];
    end else begin
      acc_next = half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == bit_cnt_t'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_r  <= a;
      b_sh <= b;
      m_r  <= m;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << 1;
    end
  end

  assign result = acc;

`include "modular_exponentiation_assert.svh"

  `MEXP_ASSERT_HOLDS(a_start_idle, start, !busy)
  `MEXP_ASSERT_NEXT(a_start_busy, start, busy)
  `MEXP_ASSERT_HOLDS(a_acc_reduced, busy, acc < m_r)

endmodule
